>>> hdl/poi_pkg.sv
// ----------------------------------------------------------------------------
// poi_pkg
// Types and constants for the planar odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam int unsigned VelW   = 24;
  localparam int unsigned GainW  = 16;
  localparam int unsigned StampW = 32;
  localparam int unsigned HeadW  = 16;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned OutPosW = 40;
  localparam int unsigned CordW  = 34;
  localparam int unsigned CordSteps = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgGainX = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgGainY = 1'b1;

  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic [63:0] InvTwoPiQ32 = 64'd683565276;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_SX, ST_MUL_SY, ST_MUL_H, ST_MUL_H2, ST_COR1,
    ST_MUL_RX1, ST_MUL_RX2, ST_MUL_RY1, ST_MUL_RY2, ST_MUL_PX, ST_MUL_PY,
    ST_COR2, ST_OUT
  } state_e;

  function automatic logic signed [CordW-1:0] atan_bam(input logic [3:0] i);
    logic signed [CordW-1:0] r;
    case (i)
      4'd0:  r = 34'sd536870912;
      4'd1:  r = 34'sd316933406;
      4'd2:  r = 34'sd167458907;
      4'd3:  r = 34'sd85004756;
      4'd4:  r = 34'sd42667331;
      4'd5:  r = 34'sd21354465;
      4'd6:  r = 34'sd10679838;
      4'd7:  r = 34'sd5340245;
      4'd8:  r = 34'sd2670163;
      4'd9:  r = 34'sd1335087;
      4'd10: r = 34'sd667544;
      4'd11: r = 34'sd333772;
      4'd12: r = 34'sd166886;
      4'd13: r = 34'sd83443;
      4'd14: r = 34'sd41722;
      default: r = 34'sd20861;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/planar_odometry_integrator_core.sv
// ----------------------------------------------------------------------------
// planar_odometry_integrator_core
// Dead-reckoning odometry: gain scaling, CORDIC rotation, position and
// heading integration, heading quaternion.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  s_axis   | in  | vel_x, vel_y, yaw_rate, stamp
//  m_axis   | out | pos_x, pos_y, heading, quat z/w, scaled vel, yaw rate
//  cfg      | in  | gain_x (0), gain_y (1)
//
// Ten products go through a shift-add multiplier, one multiplier bit per
// cycle, stopping once the remaining multiplier bits are zero; a negative
// sine or cosine, being sign-extended, runs through all multiplier bits.
// Each product is used as soon as it is complete, and the CORDIC
// rotation runs twice. One item is in work at a time; the output register
// holds the result until taken and blocks the input.
// Reset clears position, heading, last stamp and sets both gains to 1.0.
module planar_odometry_integrator_core #(
  parameter int unsigned POSITION_BITS = 40
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vel_x[23:0], vel_y[47:24], yaw_rate[71:48], stamp[103:72]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[39:0], pos_y[79:40], heading_turns[95:80], quat_z[111:96],
  // quat_w[127:112], scaled_vel_x[151:128], scaled_vel_y[175:152],
  // yaw_rate_out[199:176]
  output logic [199:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [poi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [poi_pkg::GainW-1:0]   cfg_data_i
);
  import poi_pkg::*;

  localparam int unsigned PW = POSITION_BITS;

  state_e state_q, state_d;

  logic [GainW-1:0] gain_x_q, gain_y_q;
  logic [PW-1:0] posx_q, posx_d, posy_q, posy_d;
  logic [HeadW-1:0] head_q, head_d;
  logic [StampW-1:0] last_q, last_d;

  logic signed [VelW-1:0] vx_q, vy_q, wz_q, vx_d, vy_d, wz_d;
  logic signed [VelW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [StampW-1:0] dt_q, dt_d;
  logic signed [CordW-1:0] c_q, c_d, s_q, s_d;
  logic signed [63:0] rx_q, rx_d;

  // serial multiplier: acc += a when multiplier lsb set, a shifts left
  logic [63:0] ma_q, ma_d, mb_q, mb_d, acc_q, acc_d;
  logic [6:0] cnt_q, cnt_d;

  // cordic
  logic signed [CordW-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [1:0] cq_q, cq_d;

  logic        ov_q, ov_d;
  logic [199:0] out_q, out_d;

  // position zero-extended so the output slice exists for any width
  logic [63:0] posx_ext, posy_ext;
  assign posx_ext = 64'(posx_q);
  assign posy_ext = 64'(posy_q);

  logic s_fire, m_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  function automatic logic signed [VelW-1:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[VelW-1:0];
  endfunction

  function automatic logic signed [QuatW-1:0] to_q15(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] t;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) return 16'sh7FFF;
    if (t < -34'sd32768) return 16'sh8000;
    return t[QuatW-1:0];
  endfunction

  // load cordic start state for a 32-bit angle
  task automatic cord_load(input logic [31:0] ang);
    logic [1:0] q;
    logic signed [CordW-1:0] z;
    q = ang[31:30];
    z = {4'b0, ang[29:0]};
    if (ang[29]) begin
      z = z - (34'sd1 <<< 30);
      q = q + 2'd1;
    end
    cx_d = CordicGain;
    cy_d = '0;
    cz_d = z;
    cq_d = q;
  endtask

  // multiplier load (operands pre-extended to 64 bits)
  task automatic mul_load(input logic [63:0] a, input logic [63:0] b);
    ma_d = a; mb_d = b; acc_d = '0; cnt_d = '0;
  endtask

  logic mul_done;
  assign mul_done = (cnt_q == 7'd64) || (mb_q == '0);

  logic signed [CordW-1:0] c_fin, s_fin;
  always_comb begin
    case (cq_q)
      2'd1: begin c_fin = -cy_q; s_fin = cx_q;  end
      2'd2: begin c_fin = -cx_q; s_fin = -cy_q; end
      2'd3: begin c_fin = cy_q;  s_fin = -cx_q; end
      default: begin c_fin = cx_q; s_fin = cy_q; end
    endcase
  end

  logic signed [CordW-1:0] ysh, xsh;
  logic [3:0] ci;
  assign ci  = cnt_q[3:0];
  assign ysh = cy_q >>> ci;
  assign xsh = cx_q >>> ci;

  always_comb begin
    state_d = state_q;
    posx_d = posx_q; posy_d = posy_q; head_d = head_q; last_d = last_q;
    vx_d = vx_q; vy_d = vy_q; wz_d = wz_q; sx_d = sx_q; sy_d = sy_q;
    dt_d = dt_q; c_d = c_q; s_d = s_q; rx_d = rx_q;
    ma_d = ma_q; mb_d = mb_q; acc_d = acc_q; cnt_d = cnt_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; cq_d = cq_q;
    ov_d = ov_q; out_d = out_q;
    if (m_fire) ov_d = 1'b0;

    if (state_q != ST_IDLE && state_q != ST_COR1 && state_q != ST_COR2 &&
        state_q != ST_OUT && !mul_done) begin
      if (mb_q[0]) acc_d = acc_q + ma_q;
      ma_d = ma_q << 1;
      mb_d = mb_q >> 1;
      cnt_d = cnt_q + 7'd1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            vx_d = s_axis_tdata[23:0];
            vy_d = s_axis_tdata[47:24];
            wz_d = s_axis_tdata[71:48];
            dt_d = s_axis_tdata[103:72] - last_q;
            last_d = s_axis_tdata[103:72];
            mul_load({{40{s_axis_tdata[23]}}, s_axis_tdata[23:0]}, {48'b0, gain_x_q});
            state_d = ST_MUL_SX;
          end
        end
        ST_MUL_SX: begin
          sx_d = sat24($signed(acc_q) >>> 12);
          mul_load({{40{vy_q[23]}}, vy_q}, {48'b0, gain_y_q});
          state_d = ST_MUL_SY;
        end
        ST_MUL_SY: begin
          sy_d = sat24($signed(acc_q) >>> 12);
          mul_load({{40{wz_q[23]}}, wz_q}, {32'b0, dt_q});
          state_d = ST_MUL_H;
        end
        ST_MUL_H: begin
          mul_load(acc_q, InvTwoPiQ32);
          state_d = ST_MUL_H2;
        end
        ST_MUL_H2: begin
          rx_d = $signed(acc_q);
          cord_load({head_q, 16'b0});
          cnt_d = '0;
          state_d = ST_COR1;
        end
        ST_COR1, ST_COR2: begin
          if (cnt_q == 7'(CordSteps)) begin
            if (state_q == ST_COR1) begin
              c_d = c_fin; s_d = s_fin;
              mul_load({{40{sx_q[23]}}, sx_q}, {{30{c_fin[CordW-1]}}, c_fin});
              state_d = ST_MUL_RX1;
            end else begin
              out_d = {wz_q, sy_q, sx_q, to_q15(c_fin), to_q15(s_fin), head_q,
                       posy_ext[OutPosW-1:0], posx_ext[OutPosW-1:0]};
              ov_d = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            if (!cz_q[CordW-1]) begin
              cx_d = cx_q - ysh; cy_d = cy_q + xsh; cz_d = cz_q - atan_bam(ci);
            end else begin
              cx_d = cx_q + ysh; cy_d = cy_q - xsh; cz_d = cz_q + atan_bam(ci);
            end
            cnt_d = cnt_q + 7'd1;
          end
        end
        ST_MUL_RX1: begin
          head_d = head_q + rx_q[63:48];
          rx_d = $signed(acc_q);
          mul_load({{40{sy_q[23]}}, sy_q}, {{30{s_q[CordW-1]}}, s_q});
          state_d = ST_MUL_RX2;
        end
        ST_MUL_RX2: begin
          rx_d = (rx_q - $signed(acc_q)) >>> 30;
          mul_load({{40{sx_q[23]}}, sx_q}, {{30{s_q[CordW-1]}}, s_q});
          state_d = ST_MUL_RY1;
        end
        ST_MUL_RY1: begin
          mul_load({{40{sy_q[23]}}, sy_q}, {{30{c_q[CordW-1]}}, c_q});
          // keep first product in out_q scratch
          out_d[63:0] = acc_q;
          state_d = ST_MUL_RY2;
        end
        ST_MUL_RY2: begin
          out_d[63:0] = 64'($signed(out_q[63:0] + acc_q) >>> 30);
          mul_load(rx_q, {32'b0, dt_q});
          state_d = ST_MUL_PX;
        end
        ST_MUL_PX: begin
          posx_d = posx_q + PW'($signed(acc_q) >>> 16);
          mul_load(out_q[63:0], {32'b0, dt_q});
          state_d = ST_MUL_PY;
        end
        ST_MUL_PY: begin
          posy_d = posy_q + PW'($signed(acc_q) >>> 16);
          cord_load({1'b0, head_q, 15'b0});
          cnt_d = '0;
          state_d = ST_COR2;
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gain_x_q <= 16'd4096; gain_y_q <= 16'd4096;
      posx_q <= '0; posy_q <= '0; head_q <= '0; last_q <= '0;
      ov_q <= 1'b0; cnt_q <= '0;
    end else begin
      state_q <= state_d;
      posx_q <= posx_d; posy_q <= posy_d; head_q <= head_d; last_q <= last_d;
      ov_q <= ov_d; cnt_q <= cnt_d;
      if (cfg_we_i && cfg_idx_i == CfgGainX) gain_x_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CfgGainY) gain_y_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vx_q <= vx_d; vy_q <= vy_d; wz_q <= wz_d; sx_q <= sx_d; sy_q <= sy_d;
    dt_q <= dt_d; c_q <= c_d; s_q <= s_d; rx_q <= rx_d;
    ma_q <= ma_d; mb_q <= mb_d; acc_q <= acc_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; cq_q <= cq_d;
    out_q <= out_d;
  end

endmodule

>>> tb/sv/planar_odometry_integrator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// planar_odometry_integrator_core_tb
// Self-checking bench: velocity commands go in on the input stream and each
// result is compared field by field with a bit-true odometry predictor. Gains
// are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_core_tb;
  import poi_pkg::*;

  localparam int unsigned WatchdogCycles = 20000;

  typedef struct {
    logic [39:0] pos_x;
    logic [39:0] pos_y;
    logic [15:0] heading;
    logic [15:0] quat_z;
    logic [15:0] quat_w;
    logic [23:0] svel_x;
    logic [23:0] svel_y;
    logic [23:0] yaw_rate;
  } odom_t;

  localparam longint AtanTurns[16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgGainX;
  logic [GainW-1:0]   cfg_data_i = '0;

  // predictor state
  bit   [15:0] gain_x_q, gain_y_q;
  bit   [39:0] odo_pos_x, odo_pos_y;
  bit   [15:0] odo_heading;
  bit   [31:0] odo_stamp;

  odom_t  odom_queue[$];
  int     fail_count = 0;
  bit     steady = 1'b0;
  int     quiet_cycles = 0;
  int     rdy_stall = 0;

  planar_odometry_integrator_core i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void cordic_cs(input bit [31:0] ang, output longint c,
                                    output longint s);
    bit [1:0] q;
    longint z, x, y, t;
    q = ang[31:30];
    z = longint'(ang[29:0]);
    x = 652032874;
    y = 0;
    if (z >= (64'sd1 <<< 29)) begin
      z -= (64'sd1 <<< 30);
      q = q + 2'd1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= AtanTurns[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += AtanTurns[i];
      end
      x = t;
    end
    case (q)
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      2'd3: begin c = y; s = -x; end
      default: begin c = x; s = y; end
    endcase
  endfunction

  function automatic longint sat_range(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [15:0] round_q15(longint v);
    return 16'(sat_range((v + 16384) >>> 15, -32768, 32767));
  endfunction

  function automatic odom_t integrate(logic signed [23:0] vx, logic signed [23:0] vy,
                                      logic signed [23:0] wz, logic [31:0] stamp);
    odom_t  r;
    longint sx, sy, dt, c, s, rx, ry;
    bit [63:0] turn_prod;
    sx = sat_range((longint'(vx) * longint'(gain_x_q)) >>> 12, -8388608, 8388607);
    sy = sat_range((longint'(vy) * longint'(gain_y_q)) >>> 12, -8388608, 8388607);
    dt = longint'(32'(stamp - odo_stamp));
    odo_stamp = stamp;
    cordic_cs({odo_heading, 16'h0}, c, s);
    rx = (sx * c - sy * s) >>> 30;
    ry = (sx * s + sy * c) >>> 30;
    odo_pos_x = odo_pos_x + 40'((rx * dt) >>> 16);
    odo_pos_y = odo_pos_y + 40'((ry * dt) >>> 16);
    turn_prod = 64'(longint'(wz) * dt) * 64'd683565276;
    odo_heading = odo_heading + turn_prod[63:48];
    cordic_cs({1'b0, odo_heading, 15'h0}, c, s);
    r.pos_x = odo_pos_x;
    r.pos_y = odo_pos_y;
    r.heading = odo_heading;
    r.quat_z = round_q15(s);
    r.quat_w = round_q15(c);
    r.svel_x = 24'(sx);
    r.svel_y = 24'(sy);
    r.yaw_rate = wz;
    return r;
  endfunction

  // sender: valid stays high after acceptance until the next call or halt_cmds
  task automatic send_cmd(logic [23:0] vx, logic [23:0] vy, logic [23:0] wz,
                          logic [31:0] stamp);
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {stamp, wz, vy, vx};
    do @(posedge clk_i); while (!s_axis_tready);
    odom_queue.push_back(integrate(vx, vy, wz, stamp));
    @(negedge clk_i);
  endtask

  task automatic halt_cmds();
    s_axis_tvalid <= 1'b0;
    while (odom_queue.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_gains(logic [15:0] gx, logic [15:0] gy);
    halt_cmds();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgGainX;
    cfg_data_i <= gx;
    @(negedge clk_i);
    cfg_idx_i  <= CfgGainY;
    cfg_data_i <= gy;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gain_x_q = gx;
    gain_y_q = gy;
  endtask

  task automatic random_cmd();
    logic [31:0] stamp;
    logic [23:0] vx, vy, wz;
    int pick;
    pick = $urandom_range(0, 9);
    stamp = (pick == 0) ? $urandom() : odo_stamp + $urandom_range(0, 4000);
    vx = (pick < 3) ? 24'($urandom()) : 24'($signed($urandom_range(0, 262144)) - 131072);
    vy = (pick < 3) ? 24'($urandom()) : 24'($signed($urandom_range(0, 262144)) - 131072);
    wz = (pick < 3) ? 24'($urandom()) : 24'($signed($urandom_range(0, 524288)) - 262144);
    send_cmd(vx, vy, wz, stamp);
  endtask

  task automatic test_directed();
    set_gains(16'd4096, 16'd4096);
    send_cmd(24'd65536, 24'd0, 24'd0, 32'd65536);          // first step from zero
    send_cmd(24'd0, 24'd65536, 24'd102944, 32'd131072);
    send_cmd(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'd196608);
    send_cmd(24'h800000, 24'h7FFFFF, 24'h800000, 32'd200000);
    send_cmd(24'h123456, 24'hFEDCBA, 24'd1000, 32'd100);    // stamp going backwards
    send_cmd(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'hFFFF_FFFF);
    send_cmd(24'h800000, 24'h800000, 24'h800000, 32'h7FFF_FFFF);
    send_cmd(24'd0, 24'd0, 24'd0, 32'h7FFF_FFFF);
    send_cmd(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 32'h8000_0000);
    set_gains(16'd65535, 16'd65535);                        // velocity saturation
    send_cmd(24'h7FFFFF, 24'h800000, 24'd5000, 32'h8000_1000);
    send_cmd(24'h800000, 24'h7FFFFF, 24'hFFEC78, 32'h8000_2000);
    send_cmd(24'h100000, 24'hF00000, 24'd0, 32'h8000_3000);
    set_gains(16'd0, 16'd0);
    send_cmd(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'h9000_0000);
    send_cmd(24'h555555, 24'hAAAAAA, 24'h555555, 32'h9000_0001);
  endtask

  task automatic test_random(logic [15:0] gx, logic [15:0] gy, int n, bit calm);
    set_gains(gx, gy);
    steady = calm;
    repeat (n) random_cmd();
  endtask

  // receiver ready with random stall bursts
  always @(negedge clk_i) begin
    if (rdy_stall > 0) begin
      rdy_stall <= rdy_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      rdy_stall <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    odom_t e;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      if (odom_queue.size() == 0) begin
        $error("unexpected result item");
        fail_count++;
      end else begin
        e = odom_queue.pop_front();
        if (m_axis_tdata[39:0] !== e.pos_x) begin
          $error("pos_x exp %h got %h", e.pos_x, m_axis_tdata[39:0]); fail_count++;
        end
        if (m_axis_tdata[79:40] !== e.pos_y) begin
          $error("pos_y exp %h got %h", e.pos_y, m_axis_tdata[79:40]); fail_count++;
        end
        if (m_axis_tdata[95:80] !== e.heading) begin
          $error("heading_turns exp %h got %h", e.heading, m_axis_tdata[95:80]);
          fail_count++;
        end
        if (m_axis_tdata[111:96] !== e.quat_z) begin
          $error("quat_z exp %h got %h", e.quat_z, m_axis_tdata[111:96]); fail_count++;
        end
        if (m_axis_tdata[127:112] !== e.quat_w) begin
          $error("quat_w exp %h got %h", e.quat_w, m_axis_tdata[127:112]); fail_count++;
        end
        if (m_axis_tdata[151:128] !== e.svel_x) begin
          $error("scaled_vel_x exp %h got %h", e.svel_x, m_axis_tdata[151:128]);
          fail_count++;
        end
        if (m_axis_tdata[175:152] !== e.svel_y) begin
          $error("scaled_vel_y exp %h got %h", e.svel_y, m_axis_tdata[175:152]);
          fail_count++;
        end
        if (m_axis_tdata[199:176] !== e.yaw_rate) begin
          $error("yaw_rate_out exp %h got %h", e.yaw_rate, m_axis_tdata[199:176]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= WatchdogCycles);
    $display("Verification failed");
    $finish;
  end

  initial begin
    gain_x_q = 16'd4096;
    gain_y_q = 16'd4096;
    odo_pos_x = '0;
    odo_pos_y = '0;
    odo_heading = '0;
    odo_stamp = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(16'd4096, 16'd4096, 500, 1'b0);
    test_random(16'd65535, 16'd0, 350, 1'b0);
    test_random(16'($urandom()), 16'($urandom()), 400, 1'b0);
    test_random(16'd0, 16'd65535, 300, 1'b0);
    test_random(16'd8192, 16'd2048, 390, 1'b1);
    halt_cmds();
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
